/* rtl/gcd_disp_pkg.sv */
package gcd_disp_pkg;

  // slot and word sizes
  localparam int NUM_SLOTS = 6;
  localparam int NUM_REGS  = 6;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 16;
  localparam int DIV_CNT_W = 4;

  // beat kinds on the action field
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // microprogram addresses
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_CHECK   = 3'd1,
    ST_DIV     = 3'd2,
    ST_MIN     = 3'd3,
    ST_MUL     = 3'd4,
    ST_SUB     = 3'd5,
    ST_EMIT    = 3'd6,
    ST_ADVANCE = 3'd7
  } step_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TAKE_MIN,
    OP_MULTIPLY,
    OP_SUBTRACT,
    OP_EMIT,
    OP_ADVANCE
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOT_REQ,
    C_SKIP_SLOT,
    C_DIV_MORE,
    C_OUT_BUSY,
    C_MORE_SLOTS
  } cond_t;

  // one control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } uword_t;

  // status flags seen by the sequencer
  typedef struct packed {
    logic not_req;
    logic skip_slot;
    logic div_more;
    logic out_busy;
    logic more_slots;
  } ustat_t;

  // control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      ST_IDLE:    w = '{OP_ACCEPT,   C_NOT_REQ,    ST_IDLE,  ST_CHECK};
      ST_CHECK:   w = '{OP_DIV_INIT, C_SKIP_SLOT,  ST_EMIT,  ST_DIV};
      ST_DIV:     w = '{OP_DIV_STEP, C_DIV_MORE,   ST_DIV,   ST_MIN};
      ST_MIN:     w = '{OP_TAKE_MIN, C_ALWAYS,     ST_MUL,   ST_MUL};
      ST_MUL:     w = '{OP_MULTIPLY, C_ALWAYS,     ST_SUB,   ST_SUB};
      ST_SUB:     w = '{OP_SUBTRACT, C_ALWAYS,     ST_EMIT,  ST_EMIT};
      ST_EMIT:    w = '{OP_EMIT,     C_OUT_BUSY,   ST_EMIT,  ST_ADVANCE};
      ST_ADVANCE: w = '{OP_ADVANCE,  C_MORE_SLOTS, ST_CHECK, ST_IDLE};
      default:    w = '{OP_ACCEPT,   C_ALWAYS,     ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/greedy_change_dispenser.sv */
// Change dispenser with a stock count per denomination slot. A load beat
// (action 0) sets the stock of one slot and gives no result; a request beat
// (action 1) walks all six slots in index order and gives one result beat per
// slot, the last one flagged and carrying the unpaid amount. A small
// microprogram sequences a shared datapath: an unused slot or a slot reached
// with nothing left to pay goes straight to its result beat, any other slot
// first runs the bit-per-cycle 16-step restoring divider and then the min,
// multiply and subtract steps. Input is taken only while the sequencer idles;
// a finished result waits in the output register while the next beat is taken.
module greedy_change_dispenser (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [gcd_disp_pkg::SLOT_W-1:0]      slot_select,
  input  logic [gcd_disp_pkg::DATA_W-1:0]      item_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gcd_disp_pkg::SLOT_W-1:0]      slot_index,
  output logic [gcd_disp_pkg::DATA_W-1:0]      notes_given,
  output logic [gcd_disp_pkg::DATA_W-1:0]      amount_unpaid,
  output logic                                 last_result,
  // configuration
  input  logic                                 cfg_we,
  input  logic [gcd_disp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcd_disp_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW = gcd_disp_pkg::DATA_W;
  localparam int SW = gcd_disp_pkg::SLOT_W;

  gcd_disp_pkg::step_t  step, step_next;
  gcd_disp_pkg::uword_t uw;
  gcd_disp_pkg::ustat_t stat;
  logic                 branch;

  logic [DW-1:0]   denom [gcd_disp_pkg::NUM_REGS];
  logic [DW-1:0]   stock [gcd_disp_pkg::NUM_SLOTS];
  logic [DW-1:0]   amt;
  logic [SW-1:0]   cursor;
  logic [DW-1:0]   div_q;
  logic [DW-1:0]   div_rem;
  logic [gcd_disp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [DW-1:0]   take;
  logic [2*DW-1:0] prod;

  logic [DW-1:0]   denom_cur;
  logic [DW:0]     div_shift;
  logic            div_fit;
  logic            in_accept;
  logic            is_last;

  // current slot denomination, unused beyond the register list
  always_comb begin
    if ({1'b0, cursor} < (SW+1)'(gcd_disp_pkg::NUM_REGS)) begin
      denom_cur = denom[cursor];
    end else begin
      denom_cur = '0;
    end
  end

  // divider trial subtract
  assign div_shift = {div_rem, div_q[DW-1]};
  assign div_fit   = (div_shift >= {1'b0, denom_cur});

  assign in_stall  = (step != gcd_disp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_last   = (cursor == SW'(gcd_disp_pkg::NUM_SLOTS - 1));

  // status flags for branching
  always_comb begin
    stat.not_req    = !(in_valid && (action == gcd_disp_pkg::ACT_REQUEST));
    stat.skip_slot  = (denom_cur == '0) || (amt == '0);
    stat.div_more   = (div_cnt != '0);
    stat.out_busy   = out_valid && out_stall;
    stat.more_slots = !is_last;
  end

  // control word fetch and branch select
  always_comb begin
    uw = gcd_disp_pkg::ucode(step);
    unique case (uw.cond)
      gcd_disp_pkg::C_ALWAYS:     branch = 1'b1;
      gcd_disp_pkg::C_NOT_REQ:    branch = stat.not_req;
      gcd_disp_pkg::C_SKIP_SLOT:  branch = stat.skip_slot;
      gcd_disp_pkg::C_DIV_MORE:   branch = stat.div_more;
      gcd_disp_pkg::C_OUT_BUSY:   branch = stat.out_busy;
      gcd_disp_pkg::C_MORE_SLOTS: branch = stat.more_slots;
      default:                    branch = 1'b1;
    endcase
    step_next = branch ? uw.tgt_true : uw.tgt_false;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= gcd_disp_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // denomination registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gcd_disp_pkg::NUM_REGS; i++) begin
        denom[i] <= '0;
      end
    end else if (cfg_we &&
                 ({1'b0, cfg_index} < (gcd_disp_pkg::CFG_IDX_W+1)'(gcd_disp_pkg::NUM_REGS))) begin
      denom[cfg_index] <= cfg_data;
    end
  end

  // stock store: loaded from input, lowered by the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gcd_disp_pkg::NUM_SLOTS; i++) begin
        stock[i] <= '0;
      end
    end else if (uw.op == gcd_disp_pkg::OP_ACCEPT) begin
      if (in_accept && (action == gcd_disp_pkg::ACT_LOAD) &&
          ({1'b0, slot_select} < (SW+1)'(gcd_disp_pkg::NUM_SLOTS))) begin
        stock[slot_select] <= item_value;
      end
    end else if (uw.op == gcd_disp_pkg::OP_TAKE_MIN) begin
      stock[cursor] <= stock[cursor] - ((div_q < stock[cursor]) ? div_q : stock[cursor]);
    end
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (rst) begin
      amt    <= '0;
      cursor <= '0;
    end else begin
      unique case (uw.op)
        gcd_disp_pkg::OP_ACCEPT: begin
          if (in_accept && (action == gcd_disp_pkg::ACT_REQUEST)) begin
            amt    <= item_value;
            cursor <= '0;
          end
        end
        gcd_disp_pkg::OP_SUBTRACT: begin
          amt <= amt - prod[DW-1:0];
        end
        gcd_disp_pkg::OP_ADVANCE: begin
          cursor <= is_last ? '0 : cursor + SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // shared datapath: divider, min, multiply
  always_ff @(posedge clk) begin
    unique case (uw.op)
      gcd_disp_pkg::OP_DIV_INIT: begin
        div_q   <= amt;
        div_rem <= '0;
        div_cnt <= '1;
        take    <= '0;
      end
      gcd_disp_pkg::OP_DIV_STEP: begin
        div_cnt <= div_cnt - 1'b1;
        if (div_fit) begin
          div_rem <= DW'(div_shift - {1'b0, denom_cur});
          div_q   <= {div_q[DW-2:0], 1'b1};
        end else begin
          div_rem <= div_shift[DW-1:0];
          div_q   <= {div_q[DW-2:0], 1'b0};
        end
      end
      gcd_disp_pkg::OP_TAKE_MIN: begin
        take <= (div_q < stock[cursor]) ? div_q : stock[cursor];
      end
      gcd_disp_pkg::OP_MULTIPLY: begin
        prod <= take * denom_cur;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == gcd_disp_pkg::OP_EMIT && !stat.out_busy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (uw.op == gcd_disp_pkg::OP_EMIT && !stat.out_busy) begin
      slot_index    <= cursor;
      notes_given   <= take;
      amount_unpaid <= amt;
      last_result   <= is_last;
    end
  end

endmodule

/* tb/tb.sv */
module tb;

  // sizes and beat kinds from the package
  localparam int   SLOT_W      = gcd_disp_pkg::SLOT_W;
  localparam int   DATA_W      = gcd_disp_pkg::DATA_W;
  localparam int   CFG_IDX_W   = gcd_disp_pkg::CFG_IDX_W;
  localparam int   NUM_SLOTS   = gcd_disp_pkg::NUM_SLOTS;
  localparam int   NUM_REGS    = gcd_disp_pkg::NUM_REGS;
  localparam logic ACT_LOAD    = gcd_disp_pkg::ACT_LOAD;
  localparam logic ACT_REQUEST = gcd_disp_pkg::ACT_REQUEST;

  // register map
  localparam int   DENOM_REG_BASE = 0;

  // one result beat of a request
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] notes;
    logic [DATA_W-1:0] unpaid;
    logic              last;
  } payout_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 action = ACT_LOAD;
  logic [SLOT_W-1:0]    slot_select = '0;
  logic [DATA_W-1:0]    item_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SLOT_W-1:0]    slot_index;
  logic [DATA_W-1:0]    notes_given;
  logic [DATA_W-1:0]    amount_unpaid;
  logic                 last_result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // mirror of the dispenser state
  logic [DATA_W-1:0] denom_model [NUM_SLOTS];
  logic [DATA_W-1:0] stock_model [NUM_SLOTS];
  payout_t           pending_payouts [$];

  int mismatches  = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;

  greedy_change_dispenser i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .slot_select   (slot_select),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_index    (slot_index),
    .notes_given   (notes_given),
    .amount_unpaid (amount_unpaid),
    .last_result   (last_result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // models a load, or a greedy walk over the slots that queues one payout per slot
  task automatic predict_payout(input logic act, input logic [SLOT_W-1:0] sel,
                                input logic [DATA_W-1:0] val);
    int unsigned amt;
    int unsigned want;
    int unsigned take;
    int unsigned d;
    int          s;
    payout_t     p;
    if (act == ACT_LOAD) begin
      // loads past the last slot are dropped
      if (sel < NUM_SLOTS) stock_model[sel] = val;
    end else begin
      amt = val;
      for (s = 0; s < NUM_SLOTS; s++) begin
        d = denom_model[s];
        take = 0;
        if (d != 0 && amt != 0) begin
          want = amt / d;
          take = (want < stock_model[s]) ? want : stock_model[s];
          stock_model[s] = stock_model[s] - DATA_W'(take);
          amt = amt - take * d;
        end
        p.slot   = SLOT_W'(s);
        p.notes  = DATA_W'(take);
        p.unpaid = DATA_W'(amt);
        p.last   = (s == NUM_SLOTS - 1);
        pending_payouts.push_back(p);
      end
    end
  endtask

  // offer one beat, with random gaps ahead of it
  task automatic send_beat(input logic act, input logic [SLOT_W-1:0] sel,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    slot_select <= sel;
    item_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_payout(act, sel, val);
  endtask

  // stop offering and let every payout come out
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (pending_payouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    if (idx >= DENOM_REG_BASE && idx < DENOM_REG_BASE + NUM_REGS)
      denom_model[idx - DENOM_REG_BASE] = val;
  endtask

  task automatic set_denoms(input logic [DATA_W-1:0] vals [NUM_SLOTS]);
    int s;
    for (s = 0; s < NUM_SLOTS; s++) write_reg(DENOM_REG_BASE + s, vals[s]);
    cfg_we <= 1'b0;
  endtask

  // registers at reset: every slot unused, nothing is paid
  task automatic test_power_on;
    send_beat(ACT_REQUEST, 3'd0, 16'd1234);
    send_beat(ACT_REQUEST, 3'd5, 16'd0);
  endtask

  // sorted denominations, stock limits, bad slot loads, zero and max amounts
  task automatic test_sorted_denoms;
    wait_drained();
    set_denoms('{16'd500, 16'd200, 16'd100, 16'd50, 16'd20, 16'd10});
    send_beat(ACT_LOAD, 3'd0, 16'd3);
    send_beat(ACT_LOAD, 3'd1, 16'd5);
    send_beat(ACT_LOAD, 3'd2, 16'd0);
    send_beat(ACT_LOAD, 3'd3, 16'hFFFF);
    send_beat(ACT_LOAD, 3'd4, 16'd2);
    send_beat(ACT_LOAD, 3'd5, 16'd1);
    send_beat(ACT_LOAD, SLOT_W'(NUM_SLOTS), 16'd999);
    send_beat(ACT_LOAD, '1, 16'hFFFF);
    send_beat(ACT_REQUEST, 3'd7, 16'd880);
    send_beat(ACT_REQUEST, 3'd0, 16'hFFFF);
    send_beat(ACT_REQUEST, 3'd2, 16'd7);
    send_beat(ACT_REQUEST, 3'd1, 16'd0);
  endtask

  // unsorted slots, an unused slot in the middle, extreme values
  task automatic test_unsorted_denoms;
    wait_drained();
    set_denoms('{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'hFFFF, 16'd7});
    send_beat(ACT_LOAD, 3'd0, 16'hFFFF);
    send_beat(ACT_LOAD, 3'd1, 16'd1);
    send_beat(ACT_LOAD, 3'd3, 16'd2);
    send_beat(ACT_LOAD, 3'd4, 16'd3);
    send_beat(ACT_LOAD, 3'd5, 16'hFFFF);
    send_beat(ACT_REQUEST, 3'd0, 16'hFFFF);
    send_beat(ACT_REQUEST, 3'd3, 16'hFFFF);
    send_beat(ACT_REQUEST, 3'd6, 16'hFFFE);
  endtask

  // writes past the last register must leave the denominations alone
  task automatic test_register_range;
    wait_drained();
    write_reg(NUM_REGS, 16'h0001);
    write_reg(NUM_REGS + 1, 16'hFFFF);
    cfg_we <= 1'b0;
    send_beat(ACT_REQUEST, 3'd4, 16'd100);
  endtask

  // long output hold-off while requests keep coming
  task automatic test_backpressure;
    int k;
    wait_drained();
    gap_pct   = 0;
    stall_pct = 0;
    set_denoms('{16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1});
    for (k = 0; k < NUM_SLOTS; k++) send_beat(ACT_LOAD, SLOT_W'(k), 16'd40);
    hold_cycles = 300;
    for (k = 0; k < 8; k++)
      send_beat(ACT_REQUEST, SLOT_W'($urandom), DATA_W'($urandom_range(0, 900)));
  endtask

  // random denominations, then mostly requests sized to them
  task automatic test_random_traffic(input int gap, input int stall, input int count);
    int unsigned       picks [$];
    int unsigned       reach;
    logic [DATA_W-1:0] vals [NUM_SLOTS];
    logic [SLOT_W-1:0] sel;
    logic [DATA_W-1:0] val;
    int                s;
    int                i;
    wait_drained();
    gap_pct   = gap;
    stall_pct = stall;
    for (s = 0; s < NUM_SLOTS; s++) begin
      case ($urandom_range(9))
        0:       picks.push_back(0);
        1:       picks.push_back($urandom_range(1, 65535));
        default: picks.push_back($urandom_range(1, 1000));
      endcase
    end
    if ($urandom_range(3) != 0) picks.rsort();
    for (s = 0; s < NUM_SLOTS; s++) vals[s] = DATA_W'(picks[s]);
    set_denoms(vals);
    reach = 100;
    for (s = 0; s < NUM_SLOTS; s++)
      if (denom_model[s] * 8 > reach) reach = denom_model[s] * 8;
    if (reach > 65535) reach = 65535;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35) begin
        sel = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(NUM_SLOTS, 7))
                                       : SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        val = ($urandom_range(6) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 25));
        send_beat(ACT_LOAD, sel, val);
      end else begin
        val = ($urandom_range(3) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, reach));
        send_beat(ACT_REQUEST, SLOT_W'($urandom), val);
      end
    end
  endtask

  // result side: random stalls, or a counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // compare each result beat with the oldest expected payout
  always @(posedge clk) begin : check_payouts
    payout_t got;
    payout_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{slot_index, notes_given, amount_unpaid, last_result};
      if (pending_payouts.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: slot %0d notes %0d unpaid %0d last %0b",
                   got.slot, got.notes, got.unpaid, got.last);
        mismatches++;
      end else begin
        want = pending_payouts.pop_front();
        if (got.slot !== want.slot || got.notes !== want.notes ||
            got.unpaid !== want.unpaid || got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("payout mismatch: exp slot %0d notes %0d unpaid %0d last %0b",
                     want.slot, want.notes, want.unpaid, want.last);
            $display("                 got slot %0d notes %0d unpaid %0d last %0b",
                     got.slot, got.notes, got.unpaid, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("** greedy_change_dispenser: FAILED **");
    $finish;
  end

  // test sequence
  initial begin
    foreach (denom_model[s]) begin
      denom_model[s] = '0;
      stock_model[s] = '0;
    end
    gap_pct   = 30;
    stall_pct = 65;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on();
    test_sorted_denoms();
    test_unsorted_denoms();
    test_register_range();
    test_backpressure();
    test_random_traffic(30, 65, 120);
    test_random_traffic(65, 30, 120);
    test_random_traffic(0, 0, 120);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_payouts.size() == 0) begin
      $display("** greedy_change_dispenser: PASSED **");
    end else begin
      $display("** greedy_change_dispenser: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gcd_disp_pkg.sv
rtl/greedy_change_dispenser.sv
tb/tb.sv
